@@ hw/rtl/column_top_edge_profile_top_macros.svh @@
// Assertion macros for the column top-edge profile block.
// Every macro samples on the rising edge of i_clk and is disabled while i_rst_n is low.
`ifndef COLUMN_TOP_EDGE_PROFILE_TOP_MACROS_SVH
`define COLUMN_TOP_EDGE_PROFILE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CTEP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("column top-edge profile check failed");
`define CTEP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("column top-edge profile check failed");
`define CTEP_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("column top-edge profile check failed");
`else
`define CTEP_ASSERT_SAME(label, ante, cons)
`define CTEP_ASSERT_NEXT(label, ante, cons)
`define CTEP_ASSERT_NEVER(label, cond)
`endif

`endif

@@ hw/rtl/ctep_pkg.sv @@
`default_nettype none

package ctep_pkg;

    localparam int MAX_COLUMNS_DEF = 2048;
    localparam int MAX_ROWS_DEF    = 4096;

    localparam logic [7:0]  THRESHOLD_RST = 8'd120;
    localparam logic [11:0] WIDTH_RST     = 12'd640;
    localparam logic [12:0] HEIGHT_RST    = 13'd480;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_LVL_W = OUTQ_PTR_W + 1;

    // Column store entry: found flag on top of the row where it was found.
    localparam int ENTRY_W = 13;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WHITE_THRESHOLD = 2'd0,
        REG_FRAME_WIDTH     = 2'd1,
        REG_FRAME_HEIGHT    = 2'd2
    } t_cfg_reg;

    // One pixel request as it leaves the counter stage.
    typedef struct packed {
        logic [10:0] column;
        logic [11:0] row_lo;
        logic [11:0] top_none;
        logic        fg;
        logic        first_row;
        logic        last_row;
        logic        last_col;
    } t_req;

    typedef struct packed {
        logic [10:0] column;
        logic [11:0] top_row;
        logic        last_column;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/ctep_ctrl.sv @@
`default_nettype none

module ctep_ctrl #(
    parameter int MAX_COLUMNS = ctep_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = ctep_pkg::MAX_ROWS_DEF,
    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    input  wire logic [ctep_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [ctep_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                               i_accept,
    input  wire logic [7:0]                         i_pixel,
    input  wire logic                               i_frame_start,
    output      ctep_pkg::t_req                     o_req,
    output      logic [COL_W-1:0]                   o_addr
);
    import ctep_pkg::*;

    logic [7:0]       r_threshold;
    logic [11:0]      r_frame_width;
    logic [12:0]      r_frame_height;
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] n_row;

    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;
    logic [15:0]      fw_ext;
    logic [15:0]      fh_ext;
    logic [15:0]      w_eff;
    logic [15:0]      h_eff;
    logic [15:0]      h_m1;
    logic [15:0]      col_p1;
    logic [15:0]      row_p1;
    logic [15:0]      col_ext;
    logic [15:0]      row_ext;
    logic             last_col;
    logic             last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= THRESHOLD_RST;
            r_frame_width  <= WIDTH_RST;
            r_frame_height <= HEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_WHITE_THRESHOLD: r_threshold    <= i_cfg_data[7:0];
                REG_FRAME_WIDTH:     r_frame_width  <= i_cfg_data[11:0];
                REG_FRAME_HEIGHT:    r_frame_height <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Sizes are clamped to one..the store limits.
    always_comb begin
        fw_ext = {4'b0, r_frame_width};
        fh_ext = {3'b0, r_frame_height};
        if (fw_ext == 16'd0) begin
            w_eff = 16'd1;
        end else if (fw_ext > 16'(MAX_COLUMNS)) begin
            w_eff = 16'(MAX_COLUMNS);
        end else begin
            w_eff = fw_ext;
        end
        if (fh_ext == 16'd0) begin
            h_eff = 16'd1;
        end else if (fh_ext > 16'(MAX_ROWS)) begin
            h_eff = 16'(MAX_ROWS);
        end else begin
            h_eff = fh_ext;
        end
        h_m1 = h_eff - 16'd1;
    end

    always_comb begin
        col_cur  = i_frame_start ? '0 : r_col;
        row_cur  = i_frame_start ? '0 : r_row;
        col_ext  = 16'(col_cur);
        row_ext  = 16'(row_cur);
        col_p1   = col_ext + 16'd1;
        row_p1   = row_ext + 16'd1;
        last_col = (col_p1 >= w_eff);
        last_row = (row_p1 >= h_eff);
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : row_p1[ROW_W-1:0];
        end else begin
            n_col = col_p1[COL_W-1:0];
            n_row = row_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_comb begin
        o_addr           = col_cur;
        o_req.column     = col_ext[10:0];
        o_req.row_lo     = row_ext[11:0];
        o_req.top_none   = h_m1[11:0];
        o_req.fg         = (i_pixel > r_threshold);
        o_req.first_row  = (row_cur == '0);
        o_req.last_row   = last_row;
        o_req.last_col   = last_col;
    end

endmodule

`default_nettype wire

@@ hw/rtl/ctep_store.sv @@
`default_nettype none

module ctep_store #(
    parameter int MAX_COLUMNS = ctep_pkg::MAX_COLUMNS_DEF,
    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_valid,
    input  wire ctep_pkg::t_req   i_req,
    input  wire logic [COL_W-1:0] i_addr,
    output      logic             o_busy,
    output      logic             o_res_valid,
    output      ctep_pkg::t_result o_res
);
    import ctep_pkg::*;

    logic [ENTRY_W-1:0] mem [MAX_COLUMNS];

    logic               r_s1_valid;
    t_req               r_s1_req;
    logic [COL_W-1:0]   r_s1_addr;
    logic [ENTRY_W-1:0] r_rdata;
    logic               r_fwd_valid;
    logic               n_fwd_valid;
    logic [ENTRY_W-1:0] r_fwd_data;

    logic [ENTRY_W-1:0] old_entry;
    logic [ENTRY_W-1:0] entry;

    // The write of the item in stage one and the read of the next item can hit
    // the same column in the same cycle (a one-column frame); the new entry is then
    // forwarded in place of the stale read data.
    always_comb begin
        old_entry = r_fwd_valid ? r_fwd_data : r_rdata;
        if (r_s1_req.first_row) begin
            entry = {r_s1_req.fg, 12'd0};
        end else if (!old_entry[ENTRY_W-1] && r_s1_req.fg) begin
            entry = {1'b1, r_s1_req.row_lo};
        end else begin
            entry = old_entry;
        end
        n_fwd_valid = r_s1_valid && i_req_valid && (i_addr == r_s1_addr);
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid) begin
            r_rdata <= mem[i_addr];
        end
        if (r_s1_valid) begin
            mem[r_s1_addr] <= entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_s1_valid  <= i_req_valid;
            r_fwd_valid <= n_fwd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid) begin
            r_s1_req  <= i_req;
            r_s1_addr <= i_addr;
        end
        r_fwd_data <= entry;
    end

    always_comb begin
        o_busy            = r_s1_valid;
        o_res_valid       = r_s1_valid && r_s1_req.last_row;
        o_res.column      = r_s1_req.column;
        o_res.top_row     = entry[ENTRY_W-1] ? entry[11:0] : r_s1_req.top_none;
        o_res.last_column = r_s1_req.last_col;
    end

endmodule

`default_nettype wire

@@ hw/rtl/ctep_outq.sv @@
`default_nettype none

module ctep_outq (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_push,
    input  wire ctep_pkg::t_result                   i_res,
    input  wire logic                                i_pop_ready,
    output      logic                                o_valid,
    output      ctep_pkg::t_result                   o_res,
    output      logic [ctep_pkg::OUTQ_LVL_W-1:0]     o_level
);
    import ctep_pkg::*;

    t_result                r_buf [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]  r_wr_ptr;
    logic [OUTQ_PTR_W-1:0]  r_rd_ptr;
    logic [OUTQ_LVL_W-1:0]  r_level;
    logic                   pop;

    assign pop = (r_level != '0) && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_level <= r_level + OUTQ_LVL_W'(i_push) - OUTQ_LVL_W'(pop);
        end
    end

    assign o_valid = (r_level != '0);
    assign o_res   = r_buf[r_rd_ptr];
    assign o_level = r_level;

endmodule

`default_nettype wire

@@ hw/rtl/column_top_edge_profile_top.sv @@
// Column top-edge profile.
// Grayscale pixels enter on the s_axis stream in raster order, one per request;
// tuser marks the first pixel of a frame and restarts the row and column count.
// For each column the block keeps the row of the first pixel above the white
// threshold in a column store (one read-modify-write per pixel). On every pixel
// of the last row it sends one result on m_axis: column, top row (frame height
// minus one if none) and tlast on the rightmost column.
// Throughput is one pixel per cycle while s_axis_tready is high. The store is read
// at the edge that takes a pixel and written back from the stage-one register
// when the result enters the output queue, after which m_axis_tvalid rises.
// A four-entry output queue decouples the sides: when the receiver stalls, the
// input keeps going until the queue plus the item in flight fill it, then
// s_axis_tready drops until results drain.
// Registers are written on the cfg channel (index 0 threshold, 1 width, 2 height),
// always ready; the user must write them only while the block is idle (the block does not enforce it).
// Reset clears the counters and registers to 120 / 640 / 480; the store needs
// no clearing since row zero of a frame writes every entry before its content is used.
`default_nettype none

`include "column_top_edge_profile_top_macros.svh"

module column_top_edge_profile_top #(
    parameter int MAX_COLUMNS = ctep_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = ctep_pkg::MAX_ROWS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output      logic                              o_cfg_ready,
    input  wire logic [ctep_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [ctep_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    input  wire logic [7:0]                        s_axis_tdata,  // pixel [7:0]
    input  wire logic                              s_axis_tuser,  // frame_start [0]
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output      logic [23:0]                       m_axis_tdata,  // column [10:0], top_row [22:11]
    output      logic                              m_axis_tlast   // last_column
);
    import ctep_pkg::*;

    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    logic                  accept;
    t_req                  req;
    logic [COL_W-1:0]      addr;
    logic                  s1_busy;
    logic                  res_valid;
    t_result               res;
    t_result               out_res;
    logic [OUTQ_LVL_W-1:0] level;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (level + OUTQ_LVL_W'(s1_busy)) < OUTQ_LVL_W'(OUTQ_DEPTH);
    assign o_cfg_ready   = 1'b1;

    ctep_ctrl #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_pixel       (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .o_req         (req),
        .o_addr        (addr)
    );

    ctep_store #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (accept),
        .i_req       (req),
        .i_addr      (addr),
        .o_busy      (s1_busy),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ctep_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_res       (res),
        .i_pop_ready (m_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_res       (out_res),
        .o_level     (level)
    );

    assign m_axis_tdata = {1'b0, out_res.top_row, out_res.column};
    assign m_axis_tlast = out_res.last_column;

    // The queue never takes a result when it is already full.
    `CTEP_ASSERT_NEVER(a_no_overflow, res_valid && (level == OUTQ_LVL_W'(OUTQ_DEPTH)))
    // A pixel of the last row yields its result in the cycle after it is taken.
    `CTEP_ASSERT_NEXT(a_last_row_result, accept && req.last_row, res_valid)
    // An empty queue presents nothing on the output.
    `CTEP_ASSERT_SAME(a_empty_quiet, level == '0, !m_axis_tvalid)

endmodule

`default_nettype wire
